// ----- src/rs485_pkg.sv -----
// Shared types, constants and codes for the RS485 idle-gap framer.
// No dependencies; every other file in src imports this package.
package rs485_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int RX_BUF_BYTES = 2048;
  localparam int MAX_OUT      = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int HITS_W  = $clog2(MAX_OUT + 1);
  localparam int SUM_W   = 18;

  localparam logic [3:0]  HDR_SHORT = 4'd10;
  localparam logic [3:0]  HDR_LONG  = 4'd11;
  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_SEND  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic REG_IDLE_TIMEOUT = 1'b0;
  localparam logic REG_SHORT_HDR    = 1'b1;

  typedef enum logic [1:0] {
    OP_RX       = 2'd0,
    OP_TICK     = 2'd1,
    OP_TX_START = 2'd2,
    OP_TX_EMPTY = 2'd3
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  port;
    logic [7:0]  rx_data;
    logic [15:0] tx_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  chan;
    logic [1:0]  buffer_id;
    logic [10:0] store_addr;
    logic [7:0]  store_data;
    logic        overflow;
    logic [11:0] frame_len;
    logic [15:0] send_index;
    logic        drive_tx;
    logic        last;
  } out_item_t;

  // Classified event as it sits in the queue.
  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] chan;
    logic [7:0]      rx_data;
    logic [15:0]     tx_length;
  } cmd_t;

  typedef struct packed {
    logic [15:0] idle_timeout;
    logic [3:0]  short_hdr;
  } cfg_t;

endpackage

// ----- src/rs485_front.sv -----
// Front end: accepts input words, drops events for absent channels, and
// queues classified commands for the back end. Depends on rs485_pkg.
module rs485_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rs485_pkg::in_item_t in_data,
  output logic              q_valid,
  output rs485_pkg::cmd_t   q_cmd,
  input  logic              q_pop
);
  import rs485_pkg::*;

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              accept;
  logic              keep;
  logic              push;
  logic              pop;
  cmd_t              cmd;

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.op        = op_t'(in_data.opcode);
    cmd.chan      = CH_W'(in_data.port);
    cmd.rx_data   = in_data.rx_data;
    cmd.tx_length = in_data.tx_length;
    // drop events addressed to a channel that is not built
    keep = (cmd.op == OP_TICK) || (32'(in_data.port) < NUM_CHANNELS);
  end

  assign push    = accept && keep;
  assign pop     = q_pop && q_valid;
  assign q_valid = (count_r != '0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ----- src/rs485_back.sv -----
// Back end: per-channel receive and transmit state, tick sweep of the idle
// timers, and the output word register. Depends on rs485_pkg.
module rs485_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rs485_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  rs485_pkg::cmd_t    q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rs485_pkg::out_item_t out_data
);
  import rs485_pkg::*;

  back_state_t state_r, state_nxt;

  logic        rx_active_r [NUM_CHANNELS];
  logic        rx_active_nxt [NUM_CHANNELS];
  logic [11:0] rx_count_r [NUM_CHANNELS];
  logic [11:0] rx_count_nxt [NUM_CHANNELS];
  logic [15:0] rx_time_r [NUM_CHANNELS];
  logic [15:0] rx_time_nxt [NUM_CHANNELS];
  logic [15:0] tx_rem_r [NUM_CHANNELS];
  logic [15:0] tx_rem_nxt [NUM_CHANNELS];
  logic [15:0] tx_next_r [NUM_CHANNELS];
  logic [15:0] tx_next_nxt [NUM_CHANNELS];
  logic        dir_r [NUM_CHANNELS];
  logic        dir_nxt [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] pend_r, pend_nxt;
  logic [NUM_CHANNELS-1:0] expire_mask;
  logic [NUM_CHANNELS-1:0] sweep_mask;
  logic [NUM_CHANNELS-1:0] pend_left;
  logic [HITS_W-1:0]       hits;
  logic [CH_W-1:0]         flush_ch;
  logic [CH_W-1:0]         ch;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      can_emit;
  logic      emit;
  out_item_t res;

  logic [SUM_W-1:0] addr_sum;
  logic             hdr_short;
  logic [15:0]      rem_v;
  logic [15:0]      nxt_v;

  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ch        = q_cmd.chan;

  // Channels the tick reaches, and those whose timer has run out; the sweep
  // stops once MAX_OUT frames have ended.
  always_comb begin
    hits = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      sweep_mask[c]  = (hits < HITS_W'(MAX_OUT));
      expire_mask[c] = sweep_mask[c] && rx_active_r[c] && (rx_time_r[c] == '0);
      if (expire_mask[c]) begin
        hits = hits + 1'b1;
      end
    end
  end

  // Lowest pending channel is reported first.
  always_comb begin
    flush_ch = '0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (pend_r[c]) begin
        flush_ch = CH_W'(c);
      end
    end
    pend_left           = pend_r;
    pend_left[flush_ch] = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN: begin
        if (q_valid && can_emit && (q_cmd.op == OP_TICK) && (expire_mask != '0)) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (can_emit && (pend_left == '0)) begin
          state_nxt = BK_RUN;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    rx_active_nxt = rx_active_r;
    rx_count_nxt  = rx_count_r;
    rx_time_nxt   = rx_time_r;
    tx_rem_nxt    = tx_rem_r;
    tx_next_nxt   = tx_next_r;
    dir_nxt       = dir_r;
    pend_nxt      = pend_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    res           = '0;
    addr_sum      = '0;
    hdr_short     = 1'b0;
    rem_v         = '0;
    nxt_v         = '0;

    unique case (state_r)
      BK_RUN: begin
        if (q_valid && can_emit) begin
          q_pop         = 1'b1;
          res.chan      = 2'(ch);
          res.buffer_id = 2'(ch) ^ 2'd1;
          res.last      = 1'b1;
          unique case (q_cmd.op) inside
            OP_TICK: begin
              for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (expire_mask[c]) begin
                  rx_active_nxt[c] = 1'b0;
                end else if (sweep_mask[c] && rx_active_r[c]) begin
                  rx_time_nxt[c] = rx_time_r[c] - 1'b1;
                end
              end
              pend_nxt = expire_mask;
            end
            OP_RX: begin
              emit = 1'b1;
              // a new frame starts counting from zero
              rx_count_nxt[ch]  = rx_active_r[ch] ? rx_count_r[ch] : '0;
              rx_active_nxt[ch] = 1'b1;
              hdr_short = (32'(ch) < 4) && cfg.short_hdr[2'(ch)];
              addr_sum  = SUM_W'(rx_count_nxt[ch]) +
                          SUM_W'(hdr_short ? HDR_SHORT : HDR_LONG);
              res.kind       = KIND_STORE;
              res.store_data = q_cmd.rx_data;
              if ((addr_sum < SUM_W'(RX_BUF_BYTES)) && (rx_count_nxt[ch] != COUNT_MAX)) begin
                res.store_addr   = addr_sum[10:0];
                rx_count_nxt[ch] = rx_count_nxt[ch] + 1'b1;
              end else begin
                res.overflow = 1'b1;
              end
              rx_time_nxt[ch] = cfg.idle_timeout;
              res.drive_tx    = dir_r[ch];
            end
            OP_TX_START, OP_TX_EMPTY: begin
              if (q_cmd.op == OP_TX_START) begin
                rem_v = q_cmd.tx_length;
                nxt_v = '0;
                emit  = 1'b1;
              end else begin
                rem_v = tx_rem_r[ch];
                nxt_v = tx_next_r[ch];
                emit  = dir_r[ch];
              end
              if (emit) begin
                if (rem_v != '0) begin
                  res.kind        = KIND_SEND;
                  res.send_index  = nxt_v;
                  res.drive_tx    = 1'b1;
                  tx_rem_nxt[ch]  = rem_v - 1'b1;
                  tx_next_nxt[ch] = nxt_v + 1'b1;
                  dir_nxt[ch]     = 1'b1;
                end else begin
                  res.kind        = KIND_DONE;
                  res.drive_tx    = 1'b0;
                  tx_rem_nxt[ch]  = rem_v;
                  tx_next_nxt[ch] = nxt_v;
                  dir_nxt[ch]     = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_FLUSH: begin
        if (can_emit) begin
          emit          = 1'b1;
          res.kind      = KIND_FRAME;
          res.chan      = 2'(flush_ch);
          res.buffer_id = 2'(flush_ch) ^ 2'd1;
          res.frame_len = rx_count_r[flush_ch];
          res.drive_tx  = dir_r[flush_ch];
          res.last      = (pend_left == '0);
          pend_nxt      = pend_left;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rx_active_r[c] <= 1'b0;
        rx_count_r[c]  <= '0;
        rx_time_r[c]   <= '0;
        tx_rem_r[c]    <= '0;
        tx_next_r[c]   <= '0;
        dir_r[c]       <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      rx_active_r <= rx_active_nxt;
      rx_count_r  <= rx_count_nxt;
      rx_time_r   <= rx_time_nxt;
      tx_rem_r    <= tx_rem_nxt;
      tx_next_r   <= tx_next_nxt;
      dir_r       <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- src/rs485_idle_timeout_framer.sv -----
// Top level of the RS485 idle-gap framer: register port, front end queue
// and back end engine. Depends on rs485_pkg, rs485_front, rs485_back.
//
//   port group   direction  handshake            word
//   in_*         input      in_valid / in_stall  in_item_t (event)
//   out_*        output     out_valid/out_stall  out_item_t (result)
//   p*           register   psel/penable/pready  32-bit registers at 0x0, 0x4
//
// A byte or transmit event yields at most one word. A tick first sweeps the
// idle timers, then emits one frame word per ended frame.
// A four-deep queue sits between front and back, so inputs keep flowing
// while the output register is stalled, until the queue is full. Reset is
// synchronous; no clearing pass is needed after it.
module rs485_idle_timeout_framer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rs485_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rs485_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rs485_pkg::*;

  logic [15:0] idle_timeout_r;
  logic [3:0]  short_hdr_r;
  logic        cfg_wr;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_cmd;
  cfg_t        cfg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_IDLE_TIMEOUT: prdata = 32'(idle_timeout_r);
      REG_SHORT_HDR:    prdata = 32'(short_hdr_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= 16'd5;
      short_hdr_r    <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDLE_TIMEOUT) begin
        idle_timeout_r <= pwdata[15:0];
      end else begin
        short_hdr_r <= pwdata[3:0];
      end
    end
  end

  assign cfg.idle_timeout = idle_timeout_r;
  assign cfg.short_hdr    = short_hdr_r;

  rs485_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  rs485_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/rs485_framer_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the RS485 idle-gap framer: tracks register writes, predicts
// result words for every accepted event word and compares them in order.
// Depends on rs485_pkg for the word types, codes and sizes.
module rs485_framer_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rs485_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rs485_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic [31:0]          prdata,
  output int                   errors,
  output int                   pending,
  output int                   checked
);
  import rs485_pkg::*;

  logic        frame_open [NUM_CHANNELS];
  logic [11:0] frame_bytes[NUM_CHANNELS];
  logic [17:0] gap_left   [NUM_CHANNELS];
  logic [15:0] tx_left    [NUM_CHANNELS];
  logic [15:0] tx_index   [NUM_CHANNELS];
  logic        line_tx    [NUM_CHANNELS];
  logic [15:0] gap_reload;
  logic [3:0]  short_hdr_mask;
  out_item_t   expected_words[$];

  function automatic out_item_t make_result(logic [1:0] kind, logic [1:0] ch,
                                            logic [10:0] addr, logic [7:0] data,
                                            logic ovf, logic [11:0] flen,
                                            logic [15:0] sidx);
    out_item_t r;
    r.kind       = kind;
    r.chan       = ch;
    r.buffer_id  = ch ^ 2'd1;
    r.store_addr = addr;
    r.store_data = data;
    r.overflow   = ovf;
    r.frame_len  = flen;
    r.send_index = sidx;
    r.drive_tx   = line_tx[ch];
    r.last       = 1'b0;
    return r;
  endfunction

  // Emit the next send index, or release the line once the count is spent.
  function automatic out_item_t tx_step(logic [1:0] ch);
    out_item_t r;
    if (tx_left[ch] != 16'd0) begin
      r = make_result(KIND_SEND, ch, '0, '0, 1'b0, '0, tx_index[ch]);
      tx_index[ch] = tx_index[ch] + 16'd1;
      tx_left[ch]  = tx_left[ch] - 16'd1;
    end else begin
      line_tx[ch] = 1'b0;
      r = make_result(KIND_DONE, ch, '0, '0, 1'b0, '0, '0);
    end
    return r;
  endfunction

  task automatic field_diff(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t   batch[$];
    out_item_t   want;
    out_item_t   tail;
    logic [1:0]  ch;
    int          addr;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        frame_open[c]  = 1'b0;
        frame_bytes[c] = '0;
        gap_left[c]    = '0;
        tx_left[c]     = '0;
        tx_index[c]    = '0;
        line_tx[c]     = 1'b0;
      end
      gap_reload     = 16'd5;
      short_hdr_mask = 4'd0;
      expected_words.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, out_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          checked++;
          field_diff("kind",       32'(want.kind),       32'(out_data.kind));
          field_diff("chan",       32'(want.chan),       32'(out_data.chan));
          field_diff("buffer_id",  32'(want.buffer_id),  32'(out_data.buffer_id));
          field_diff("store_addr", 32'(want.store_addr), 32'(out_data.store_addr));
          field_diff("store_data", 32'(want.store_data), 32'(out_data.store_data));
          field_diff("overflow",   32'(want.overflow),   32'(out_data.overflow));
          field_diff("frame_len",  32'(want.frame_len),  32'(out_data.frame_len));
          field_diff("send_index", 32'(want.send_index), 32'(out_data.send_index));
          field_diff("drive_tx",   32'(want.drive_tx),   32'(out_data.drive_tx));
          field_diff("last",       32'(want.last),       32'(out_data.last));
        end
      end

      if (in_valid && !in_stall) begin
        batch.delete();
        ch = in_data.port;
        case (in_data.opcode)
          OP_TICK: begin
            // Sweep in channel order; an expired timer closes its frame.
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (frame_open[c] && batch.size() < MAX_OUT) begin
                if (gap_left[c] == '0) begin
                  frame_open[c] = 1'b0;
                  batch.push_back(make_result(KIND_FRAME, c[1:0], '0, '0, 1'b0,
                                              frame_bytes[c], '0));
                end else begin
                  gap_left[c] = gap_left[c] - 18'd1;
                end
              end
            end
          end
          OP_RX: if (ch < NUM_CHANNELS) begin
            if (!frame_open[ch]) begin
              frame_open[ch]  = 1'b1;
              frame_bytes[ch] = '0;
            end
            addr = int'(short_hdr_mask[ch] ? HDR_SHORT : HDR_LONG) + int'(frame_bytes[ch]);
            if (addr < RX_BUF_BYTES && frame_bytes[ch] < COUNT_MAX) begin
              batch.push_back(make_result(KIND_STORE, ch, addr[10:0], in_data.rx_data,
                                          1'b0, '0, '0));
              frame_bytes[ch] = frame_bytes[ch] + 12'd1;
            end else begin
              batch.push_back(make_result(KIND_STORE, ch, '0, in_data.rx_data,
                                          1'b1, '0, '0));
            end
            gap_left[ch] = {2'b00, gap_reload};
          end
          OP_TX_START: if (ch < NUM_CHANNELS) begin
            tx_left[ch]  = in_data.tx_length;
            tx_index[ch] = '0;
            line_tx[ch]  = 1'b1;
            batch.push_back(tx_step(ch));
          end
          default: if (ch < NUM_CHANNELS && line_tx[ch]) begin
            batch.push_back(tx_step(ch));
          end
        endcase
        if (batch.size() > 0) begin
          tail = batch.pop_back();
          tail.last = 1'b1;
          batch.push_back(tail);
        end
        foreach (batch[i]) expected_words.push_back(batch[i]);
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_IDLE_TIMEOUT) gap_reload = pwdata[15:0];
          else short_hdr_mask = pwdata[3:0];
        end else begin
          field_diff("prdata", (paddr[2] == REG_IDLE_TIMEOUT) ? {16'h0, gap_reload}
                                                               : {28'h0, short_hdr_mask},
                     prdata);
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

// ----- tb/sv/tb_rs485_idle_timeout_framer.sv -----
`timescale 1ns / 100ps
// Top of the RS485 framer testbench: clock, reset, register programming and
// event stimulus; rs485_framer_checker does all prediction and comparison.
// Depends on rs485_pkg, rs485_idle_timeout_framer and rs485_framer_checker.
module tb_rs485_idle_timeout_framer;
  import rs485_pkg::*;

  localparam int TIMEOUT_CYCLES = 20000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_WORDS   = 30;
  localparam int BURST_BYTES    = 12;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          errors;
  int          pending;
  int          checked;
  int          cycle_count  = 0;
  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  int          words_sent   = 0;
  logic [1:0]  tx_focus     = '0;

  rs485_idle_timeout_framer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rs485_framer_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("%0t: run timed out with %0d result words outstanding", $time, pending);
      $display("tb_rs485_idle_timeout_framer: errors");
      $finish;
    end
  end

  function automatic in_item_t make_word(op_t op, logic [1:0] port, logic [7:0] data,
                                         logic [15:0] len);
    in_item_t w;
    w.opcode    = op;
    w.port      = port;
    w.rx_data   = data;
    w.tx_length = len;
    return w;
  endfunction

  // Present one word, optionally after an idle gap, and hold it until taken.
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid, drain every expected word, then let in-flight events finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] timeout, input logic [3:0] mask);
    cfg_access(1'b1, REG_IDLE_TIMEOUT, {16'h0, timeout});
    cfg_access(1'b1, REG_SHORT_HDR, {28'h0, mask});
    cfg_access(1'b0, REG_IDLE_TIMEOUT, '0);
    cfg_access(1'b0, REG_SHORT_HDR, '0);
  endtask

  initial begin
    in_item_t directed[$];
    in_item_t w;
    int       pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: idle tick, idle transmitter, rx extremes,
    // transmit restart, zero length, rx during tx, four frames ending at once.
    send_gap_pct = 9;
    stall_pct   <= 49;
    directed.push_back(make_word(OP_TICK,     2'd0, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_TX_EMPTY, 2'd0, 8'hFF, 16'hFFFF));
    directed.push_back(make_word(OP_RX,       2'd0, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_RX,       2'd0, 8'hFF, 16'hFFFF));
    directed.push_back(make_word(OP_RX,       2'd3, 8'hA5, 16'h0000));
    directed.push_back(make_word(OP_TX_START, 2'd1, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_TX_START, 2'd2, 8'h00, 16'h0002));
    directed.push_back(make_word(OP_TX_EMPTY, 2'd2, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_TX_START, 2'd2, 8'h00, 16'hFFFF));
    directed.push_back(make_word(OP_TX_EMPTY, 2'd2, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_TX_START, 2'd2, 8'h00, 16'h0001));
    directed.push_back(make_word(OP_TX_EMPTY, 2'd2, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_TX_EMPTY, 2'd2, 8'h00, 16'h0000));
    directed.push_back(make_word(OP_TX_START, 2'd3, 8'h00, 16'h0003));
    directed.push_back(make_word(OP_RX,       2'd3, 8'h3C, 16'h0000));
    directed.push_back(make_word(OP_RX,       2'd1, 8'h5A, 16'h0000));
    directed.push_back(make_word(OP_RX,       2'd2, 8'h81, 16'h0000));
    repeat (6) directed.push_back(make_word(OP_TICK, 2'd3, 8'hFF, 16'hFFFF));
    foreach (directed[i]) send_word(directed[i]);

    // One frame on channel 2 stays open across ticks under the longest timeout.
    settle();
    program_regs(16'hFFFF, 4'hF);
    send_gap_pct = 0;
    stall_pct   <= 0;
    repeat (BURST_BYTES)
      send_word(make_word(OP_RX, 2'd2, 8'($urandom_range(255)),
                          16'($urandom_range(65535))));
    repeat (3) send_word(make_word(OP_TICK, 2'd2, 8'h00, 16'h0000));
    settle();
    program_regs(16'h0000, 4'h0);
    send_word(make_word(OP_RX, 2'd2, 8'h7E, 16'h0000));
    send_word(make_word(OP_TICK, 2'd0, 8'h00, 16'h0000));

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          program_regs(16'd1, 4'($urandom_range(15)));
          send_gap_pct = 9;
          stall_pct   <= 49;
        end
        1: begin
          program_regs(16'($urandom_range(3, 2)), 4'($urandom_range(15)));
          send_gap_pct = 49;
          stall_pct   <= 9;
        end
        default: begin
          program_regs(16'($urandom_range(4)), 4'($urandom_range(15)));
          send_gap_pct = 0;
          stall_pct   <= 0;
        end
      endcase
      repeat (RANDOM_WORDS) begin
        w.port      = 2'($urandom_range(3));
        w.rx_data   = 8'($urandom_range(255));
        w.tx_length = 16'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 35) begin
          w.opcode = OP_RX;
        end else if (pick < 65) begin
          w.opcode = OP_TICK;
        end else if (pick < 75) begin
          w.opcode = OP_TX_START;
          tx_focus = w.port;
          if ($urandom_range(7) != 0) w.tx_length = 16'($urandom_range(4));
        end else begin
          // Mostly follow up the latest transfer so it runs to completion.
          w.opcode = OP_TX_EMPTY;
          if ($urandom_range(3) != 0) w.port = tx_focus;
        end
        send_word(w);
      end
    end

    settle();
    $display("Covered %0d event words: directed cases, long-timeout frame, three phases",
             words_sent);
    $display("%0d result words compared against prediction", checked);
    if (errors == 0) begin
      $display("tb_rs485_idle_timeout_framer: clean");
    end else begin
      $display("tb_rs485_idle_timeout_framer: errors");
    end
    $finish;
  end

endmodule
